// ===== src/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int COORD_W        = 32;
	localparam int HEAD_W         = 16;
	localparam int HEAD_FRAC      = HEAD_W - 2;
	localparam int DIFF_W         = COORD_W + 1;
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = COORD_W / BITS_PER_STAGE;
	// prep register, quotient stages, saturation register
	localparam int DIV_LAT        = DIV_STAGES + 2;
	localparam int CFG_IDX_W      = 3;
	localparam int NUM_AXES       = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [HEAD_W-1:0]  head_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_X  = 3'd0,
		REG_LOW_Y  = 3'd1,
		REG_LOW_Z  = 3'd2,
		REG_HIGH_X = 3'd3,
		REG_HIGH_Y = 3'd4,
		REG_HIGH_Z = 3'd5
	} reg_idx_t;

	localparam coord_t T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// per-item control that travels beside the dividers
	typedef struct packed {
		logic                valid;
		logic [NUM_AXES-1:0] zero;
		logic [NUM_AXES-1:0] fail;
	} ctl_t;

endpackage

// ===== src/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined signed divider: t = diff * 2^HEAD_FRAC / heading, truncated
// toward zero and saturated to the distance range. BITS_PER_STAGE quotient
// bits per stage, one new operand pair per cycle.
// ----------------------------------------------------------------------------
module rbst_div (
	input  logic           clk,
	input  rbst_pkg::diff_t dividend,
	input  rbst_pkg::head_t divisor,
	output rbst_pkg::coord_t quot
);
	import rbst_pkg::*;

	logic [HEAD_W-1:0]  rem_s [DIV_STAGES+1];
	logic [COORD_W-1:0] low_s [DIV_STAGES+1];
	logic [COORD_W-1:0] quo_s [DIV_STAGES+1];
	logic [HEAD_W-1:0]  ah_s  [DIV_STAGES+1];
	logic               neg_s [DIV_STAGES+1];
	logic               ovf_s [DIV_STAGES+1];

	logic [DIFF_W-1:0]  ad_full;
	logic [COORD_W-1:0] ad;
	logic [HEAD_W-1:0]  ah;
	logic [HEAD_W-1:0]  rem_init;

	always_comb begin
		ad_full  = dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
		ad       = ad_full[COORD_W-1:0];
		ah       = divisor[HEAD_W-1] ? HEAD_W'(-divisor) : HEAD_W'(divisor);
		rem_init = HEAD_W'(ad[COORD_W-1 -: HEAD_FRAC]);
	end

	// quotient beyond COORD_W bits shows up as a top remainder >= divisor
	always_ff @(posedge clk) begin
		rem_s[0] <= rem_init;
		low_s[0] <= {ad[COORD_W-HEAD_FRAC-1:0], {HEAD_FRAC{1'b0}}};
		quo_s[0] <= '0;
		ah_s[0]  <= ah;
		neg_s[0] <= dividend[DIFF_W-1] ^ divisor[HEAD_W-1];
		ovf_s[0] <= rem_init >= ah;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [HEAD_W-1:0]  r_nx;
		logic [COORD_W-1:0] l_nx;
		logic [COORD_W-1:0] q_nx;

		always_comb begin
			logic [HEAD_W:0] cand;
			r_nx = rem_s[k];
			l_nx = low_s[k];
			q_nx = quo_s[k];
			for (int b = 0; b < BITS_PER_STAGE; b++) begin
				cand = {r_nx, l_nx[COORD_W-1]};
				l_nx = {l_nx[COORD_W-2:0], 1'b0};
				if (cand >= {1'b0, ah_s[k]}) begin
					r_nx = HEAD_W'(cand - {1'b0, ah_s[k]});
					q_nx = {q_nx[COORD_W-2:0], 1'b1};
				end else begin
					r_nx = cand[HEAD_W-1:0];
					q_nx = {q_nx[COORD_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= r_nx;
			low_s[k+1] <= l_nx;
			quo_s[k+1] <= q_nx;
			ah_s[k+1]  <= ah_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	logic [COORD_W-1:0] q_fin;
	logic               neg_fin;
	logic               sat;

	always_comb begin
		q_fin   = quo_s[DIV_STAGES];
		neg_fin = neg_s[DIV_STAGES];
		// negative side reaches one further than the positive side
		sat = ovf_s[DIV_STAGES] ||
			(neg_fin ? (q_fin[COORD_W-1] && (|q_fin[COORD_W-2:0])) : q_fin[COORD_W-1]);
	end

	always_ff @(posedge clk) begin
		if (sat) begin
			quot <= neg_fin ? T_MIN : T_MAX;
		end else begin
			quot <= neg_fin ? coord_t'(-q_fin) : coord_t'(q_fin);
		end
	end

endmodule

// ===== src/ray_box_slab_test_unit.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Ray against axis-aligned box by the slab method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Box bounds are written through wr_en/wr_index/wr_data (index 0..5 =
//   low x,y,z then high x,y,z); other indexes are dropped. Write them only
//   while no ray is in flight.
//   A ray transfer happens on a clock edge with start high; busy is always
//   low, so a new ray can be sent every cycle.
//   Each ray yields one result: done pulses for one cycle with hit valid.
//   Throughput is one ray per cycle. The pipeline holds the six dividers,
//   which retire 4 quotient bits per stage, plus slab ordering and the
//   near/far reduction.
//   The receiver cannot stall; results are presented exactly once.
//   Reset clears the box registers to zero and drops all rays in flight.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rbst_pkg::coord_t                   origin_x,
	input  rbst_pkg::coord_t                   origin_y,
	input  rbst_pkg::coord_t                   origin_z,
	input  rbst_pkg::head_t                    heading_x,
	input  rbst_pkg::head_t                    heading_y,
	input  rbst_pkg::head_t                    heading_z,
	output logic                               done,
	output logic                               hit,
	input  logic                               wr_en,
	input  logic [rbst_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [rbst_pkg::COORD_W-1:0]       wr_data
);
	import rbst_pkg::*;

	coord_t box_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) box_q[i] <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_LOW_X:  box_q[0] <= wr_data;
				REG_LOW_Y:  box_q[1] <= wr_data;
				REG_LOW_Z:  box_q[2] <= wr_data;
				REG_HIGH_X: box_q[3] <= wr_data;
				REG_HIGH_Y: box_q[4] <= wr_data;
				REG_HIGH_Z: box_q[5] <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	coord_t org [NUM_AXES];
	head_t  hd  [NUM_AXES];

	always_comb begin
		org[0] = origin_x;
		org[1] = origin_y;
		org[2] = origin_z;
		hd[0]  = heading_x;
		hd[1]  = heading_y;
		hd[2]  = heading_z;
	end

	// stage 1: distances from origin to both bounds
	diff_t d_lo_s1 [NUM_AXES];
	diff_t d_hi_s1 [NUM_AXES];
	head_t hd_s1   [NUM_AXES];
	logic  v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			d_lo_s1[a] <= diff_t'({box_q[a][COORD_W-1], box_q[a]}) -
				diff_t'({org[a][COORD_W-1], org[a]});
			d_hi_s1[a] <= diff_t'({box_q[a+3][COORD_W-1], box_q[a+3]}) -
				diff_t'({org[a][COORD_W-1], org[a]});
			hd_s1[a]   <= hd[a];
		end
	end

	ctl_t ctl_s1;

	always_comb begin
		ctl_s1.valid = v_s1;
		for (int a = 0; a < NUM_AXES; a++) begin
			ctl_s1.zero[a] = hd_s1[a] == '0;
			// origin inside the slab, bounds in either order
			ctl_s1.fail[a] = ctl_s1.zero[a] &&
				!((d_lo_s1[a] <= 0 && d_hi_s1[a] >= 0) ||
				  (d_hi_s1[a] <= 0 && d_lo_s1[a] >= 0));
		end
	end

	coord_t t_lo [NUM_AXES];
	coord_t t_hi [NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		rbst_div u_div_lo (
			.clk      (clk),
			.dividend (d_lo_s1[a]),
			.divisor  (hd_s1[a]),
			.quot     (t_lo[a])
		);
		rbst_div u_div_hi (
			.clk      (clk),
			.dividend (d_hi_s1[a]),
			.divisor  (hd_s1[a]),
			.quot     (t_hi[a])
		);
	end

	ctl_t ctl_dly_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) ctl_dly_q[i] <= '0;
		end else begin
			ctl_dly_q[0] <= ctl_s1;
			for (int i = 1; i < DIV_LAT; i++) ctl_dly_q[i] <= ctl_dly_q[i-1];
		end
	end

	// stage 3: order each slab into near/far; a zero heading gives the full range
	coord_t near_s3 [NUM_AXES];
	coord_t far_s3  [NUM_AXES];
	logic   v_s3;
	logic   fail_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= ctl_dly_q[DIV_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		fail_s3 <= |ctl_dly_q[DIV_LAT-1].fail;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (ctl_dly_q[DIV_LAT-1].zero[a]) begin
				near_s3[a] <= T_MIN;
				far_s3[a]  <= T_MAX;
			end else if (t_lo[a] < t_hi[a]) begin
				near_s3[a] <= t_lo[a];
				far_s3[a]  <= t_hi[a];
			end else begin
				near_s3[a] <= t_hi[a];
				far_s3[a]  <= t_lo[a];
			end
		end
	end

	// stage 4: largest near, smallest far
	coord_t tnear_c;
	coord_t tfar_c;
	coord_t tnear_s4;
	coord_t tfar_s4;
	logic   v_s4;
	logic   fail_s4;

	always_comb begin
		tnear_c = T_MIN;
		tfar_c  = T_MAX;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (near_s3[a] > tnear_c) tnear_c = near_s3[a];
			if (far_s3[a] < tfar_c)   tfar_c  = far_s3[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tnear_s4 <= tnear_c;
		tfar_s4  <= tfar_c;
		fail_s4  <= fail_s3;
	end

	logic done_q;
	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= !fail_s4 && !(tfar_s4 < 0) && !(tnear_s4 > tfar_s4);
	end

	assign done = done_q;
	assign hit  = hit_q;

endmodule
